// ----- rtl/vnorm_pkg.sv -----
package vnorm_pkg;

  localparam int unsigned CW    = 32;  // component width
  localparam int unsigned SW    = 64;  // sum-of-squares width
  localparam int unsigned RW    = 32;  // root width
  localparam int unsigned SQ_ST = 32;  // square-root stages, one result bit each
  localparam int unsigned DV_ST = 31;  // divider stages, one quotient bit each
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // data riding along the square-root pipe
  typedef struct packed {
    logic [2:0][CW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
    logic [4:0]         k;
  } side_t;

  // data riding along the divider pipe
  typedef struct packed {
    logic [2:0]    neg;
    logic [CW-1:0] len;
    logic          zero;
  } dinfo_t;

  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) n = 5'(15 - i);
    end
    return n;
  endfunction

endpackage

// ----- rtl/vnorm_sq_lane.sv -----
// Magnitude and square of one component.
module vnorm_sq_lane (
  input  logic                         clk,
  input  logic                         en,
  input  logic [vnorm_pkg::CW-1:0]     comp,
  output logic [vnorm_pkg::CW-1:0]     mag_r,
  output logic                         neg_r,
  output logic [vnorm_pkg::SW-1:0]     sq_r
);

  logic [vnorm_pkg::CW-1:0] mag;

  assign mag = comp[vnorm_pkg::CW-1] ? (~comp + 1'b1) : comp;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag;
      neg_r <= comp[vnorm_pkg::CW-1];
      sq_r  <= mag * mag;
    end
  end

endmodule

// ----- rtl/vnorm_sqrt.sv -----
// Pipelined restoring square root, one root bit per stage.
module vnorm_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vnorm_pkg::SW-1:0]    sn,
  input  vnorm_pkg::side_t            side_in,
  output logic [vnorm_pkg::RW-1:0]    root,
  output logic [vnorm_pkg::RW+1:0]    rem,
  output vnorm_pkg::side_t            side_out
);

  localparam int unsigned N = vnorm_pkg::SQ_ST;

  logic [vnorm_pkg::RW+1:0] rem_r  [1:N];
  logic [vnorm_pkg::RW-1:0] res_r  [1:N];
  logic [vnorm_pkg::SW-1:0] sn_r   [1:N];
  vnorm_pkg::side_t         side_r [1:N];

  for (genvar j = 0; j < N; j++) begin : g_st
    logic [vnorm_pkg::RW+1:0] rem_c;
    logic [vnorm_pkg::RW-1:0] res_c;
    logic [vnorm_pkg::SW-1:0] sn_c;
    vnorm_pkg::side_t         side_c;
    logic [vnorm_pkg::RW+3:0] t;
    logic [vnorm_pkg::RW+3:0] trial;
    logic                     ge;

    // first stage starts from the module inputs
    if (j == 0) begin : g_first
      assign rem_c  = '0;
      assign res_c  = '0;
      assign sn_c   = sn;
      assign side_c = side_in;
    end else begin : g_next
      assign rem_c  = rem_r[j];
      assign res_c  = res_r[j];
      assign sn_c   = sn_r[j];
      assign side_c = side_r[j];
    end

    assign t     = {rem_c, sn_c[63-2*j -: 2]};
    assign trial = {2'b00, res_c, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? 34'(t - trial) : t[vnorm_pkg::RW+1:0];
        res_r[j+1]  <= {res_c[vnorm_pkg::RW-2:0], ge};
        sn_r[j+1]   <= sn_c;
        side_r[j+1] <= side_c;
      end
    end
  end

  assign root     = res_r[N];
  assign rem      = rem_r[N];
  assign side_out = side_r[N];

endmodule

// ----- rtl/vnorm_div_lane.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in DV_ST bits (numerator top part below divisor).
module vnorm_div_lane (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vnorm_pkg::SW-1:0]      num,
  input  logic [vnorm_pkg::RW-1:0]      den,
  output logic [vnorm_pkg::DV_ST-1:0]   quo
);

  localparam int unsigned N = vnorm_pkg::DV_ST;

  logic [vnorm_pkg::RW:0]   rem_r [1:N];
  logic [N-1:0]             q_r   [1:N];
  logic [N-1:0]             lo_r  [1:N];
  logic [vnorm_pkg::RW-1:0] d_r   [1:N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [vnorm_pkg::RW:0]   rem_c;
    logic [N-1:0]             q_c;
    logic [N-1:0]             lo_c;
    logic [vnorm_pkg::RW-1:0] d_c;
    logic [vnorm_pkg::RW+1:0] t;
    logic                     ge;

    // first stage starts from the module inputs
    if (i == 0) begin : g_first
      assign rem_c = num[vnorm_pkg::SW-1:N];
      assign q_c   = '0;
      assign lo_c  = num[N-1:0];
      assign d_c   = den;
    end else begin : g_next
      assign rem_c = rem_r[i];
      assign q_c   = q_r[i];
      assign lo_c  = lo_r[i];
      assign d_c   = d_r[i];
    end

    assign t  = {rem_c, lo_c[N-1-i]};
    assign ge = (t >= {2'b00, d_c});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? 33'(t - {2'b00, d_c}) : t[vnorm_pkg::RW:0];
        q_r[i+1]   <= {q_c[N-2:0], ge};
        lo_r[i+1]  <= lo_c;
        d_r[i+1]   <= d_c;
      end
    end
  end

  assign quo = q_r[N];

endmodule

// ----- rtl/vector_normalize_unit.sv -----
// channel | ports  | tdata (low bit up)                      | tuser
// --------+--------+-----------------------------------------+------------
// input   | in_*   | vec_x[31:0] vec_y[63:32] vec_z[95:64]    | -
// result  | out_*  | unit_x unit_y unit_z vec_length (128b)  | zero_length
//
// Rate: one item per cycle, unless the output stalls (see below). The pipe
// holds the 32-stage square root and the 31-stage divider lanes, each
// producing one bit per stage.
// Reset: rst_n (synchronous, active low) clears the valid chain only.
// Stalls: the whole pipe advances whenever the output register is empty or
// being taken; in_tready follows that same enable, so a waiting result holds
// every stage in place and nothing is lost.
module vector_normalize_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [95:0]   in_tdata,   // vec_x, vec_y, vec_z
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // unit_x, unit_y, unit_z, vec_length
  output logic          out_tuser   // zero_length
);

  localparam int unsigned CW = vnorm_pkg::CW;
  localparam int unsigned NV = 4 + vnorm_pkg::SQ_ST + 1 + vnorm_pkg::DV_ST;

  logic en;
  logic [NV-1:0] v_r;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v_r          <= {v_r[NV-2:0], in_tvalid};
      out_tvalid_r <= v_r[NV-1];
    end
  end

  // ---- lanes: magnitude and square
  logic [2:0][CW-1:0]  mag0;
  logic [2:0]          neg0;
  logic [2:0][63:0]    sq0;

  for (genvar l = 0; l < 3; l++) begin : g_sq
    vnorm_sq_lane u_sq (
      .clk   (clk),
      .en    (en),
      .comp  (in_tdata[CW*l +: CW]),
      .mag_r (mag0[l]),
      .neg_r (neg0[l]),
      .sq_r  (sq0[l])
    );
  end

  // ---- merge: sum of squares
  logic [63:0]        s1_r;
  logic [2:0][CW-1:0] mag1_r, mag2_r;
  logic [2:0]         neg1_r, neg2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= sq0[0] + sq0[1] + sq0[2];
      mag1_r <= mag0;
      neg1_r <= neg0;
    end
  end

  // ---- leading-zero count, split over two stages
  logic [63:0]      s2_r;
  logic [3:0][4:0]  cz2_r;
  logic [3:0]       nz2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s1_r;
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      for (int c = 0; c < 4; c++) begin
        cz2_r[c] <= vnorm_pkg::lzc16(s1_r[16*c +: 16]);
        nz2_r[c] <= |s1_r[16*c +: 16];
      end
    end
  end

  logic [6:0] lz;
  logic [4:0] k2;

  always_comb begin
    if (nz2_r[3])      lz = {2'b00, cz2_r[3]};
    else if (nz2_r[2]) lz = 7'd16 + {2'b00, cz2_r[2]};
    else if (nz2_r[1]) lz = 7'd32 + {2'b00, cz2_r[1]};
    else               lz = 7'd48 + {2'b00, cz2_r[0]};
    k2 = lz[5:1];
  end

  logic [63:0]      sn3_r;
  vnorm_pkg::side_t side3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sn3_r        <= s2_r << {k2, 1'b0};
      side3_r.mag  <= mag2_r;
      side3_r.neg  <= neg2_r;
      side3_r.zero <= ~|nz2_r;
      side3_r.k    <= k2;
    end
  end

  // ---- square root of the normalized sum
  logic [31:0]      root;
  logic [33:0]      srem;
  vnorm_pkg::side_t side4;

  vnorm_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .sn       (sn3_r),
    .side_in  (side3_r),
    .root     (root),
    .rem      (srem),
    .side_out (side4)
  );

  // ---- length rounding and divider operands
  // floor(sqrt(S)) = root >> k; round up from bit k-1, or from the
  // remainder when no shift was applied.
  logic              rnd;
  logic [4:0]        km1;
  logic [2:0][63:0]  num;

  assign km1 = side4.k - 5'd1;
  assign rnd = (side4.k == 5'd0) ? (srem > {2'b00, root}) : root[km1];

  for (genvar l = 0; l < 3; l++) begin : g_num
    assign num[l] = ({32'd0, side4.mag[l]} << ({1'b0, side4.k} + 6'd30))
                    + {33'd0, root[31:1]};
  end

  logic [2:0][63:0]  num5_r;
  logic [31:0]       den5_r;
  vnorm_pkg::dinfo_t dinf_r [0:vnorm_pkg::DV_ST];

  always_ff @(posedge clk) begin
    if (en) begin
      num5_r         <= num;
      den5_r         <= root;
      dinf_r[0].neg  <= side4.neg;
      dinf_r[0].len  <= (root >> side4.k) + {31'd0, rnd};
      dinf_r[0].zero <= side4.zero;
      for (int i = 0; i < vnorm_pkg::DV_ST; i++) dinf_r[i+1] <= dinf_r[i];
    end
  end

  // ---- divider lanes
  logic [2:0][vnorm_pkg::DV_ST-1:0] quo;

  for (genvar l = 0; l < 3; l++) begin : g_div
    vnorm_div_lane u_div (
      .clk (clk),
      .en  (en),
      .num (num5_r[l]),
      .den (den5_r),
      .quo (quo[l])
    );
  end

  // ---- saturate, restore sign, output register
  vnorm_pkg::dinfo_t  dlast;
  logic [2:0][CW-1:0] unit;
  logic [127:0]       out_tdata_r;
  logic               out_tuser_r;

  assign dlast = dinf_r[vnorm_pkg::DV_ST];

  for (genvar l = 0; l < 3; l++) begin : g_fmt
    logic [30:0] qs;
    assign qs      = (quo[l] > vnorm_pkg::ONE_Q30) ? vnorm_pkg::ONE_Q30 : quo[l];
    assign unit[l] = dlast.zero ? '0 :
                     dlast.neg[l] ? (~{1'b0, qs} + 1'b1) : {1'b0, qs};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= {(dlast.zero ? 32'd0 : dlast.len), unit[2], unit[1], unit[0]};
      out_tuser_r <= dlast.zero;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---- checks
  a_zero_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 128'd0)
    else $error("zero-length item with nonzero fields");

  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_stall_in : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipe stalled");

  a_unit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[96 +: 32] != 32'd0)
    else $error("nonzero vector with zero length");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  // One vector per item: x, y, z in signed Q16.16.
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vec_t;

  // One normalized result per item.
  typedef struct {
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] uz;
    logic [31:0] len;
    logic        zero;
  } unit_t;

  // Directed vector, plus a typed-in result where one is obvious.
  typedef struct {
    vec_t  v;
    bit    known;
    unit_t r;
  } row_t;

  localparam int NUM_RANDOM = 1900;
  localparam int LATENCY    = 69;
  localparam logic [63:0] ONE_Q30 = 64'h4000_0000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         out_tuser;

  unit_t expected_units[$];
  int    errors;
  bit    sending_done;

  vector_normalize_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root, 64-bit
  function automatic logic [63:0] floor_sqrt(input logic [63:0] s, output logic [63:0] rem);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    rem = s;
    return res;
  endfunction

  function automatic logic [31:0] scale_component(input logic [31:0] c, input int k,
                                                   input logic [63:0] r);
    logic [63:0]  mag;
    logic [127:0] num;
    logic [127:0] q;
    mag = c[31] ? (64'd1 << 32) - {32'd0, c} : {32'd0, c};
    num = {64'd0, mag} << (k + 30);
    q = (num + (r >> 1)) / r;
    if (q > ONE_Q30) q = ONE_Q30;
    return c[31] ? 32'(0 - q[31:0]) : q[31:0];
  endfunction

  function automatic unit_t normalize(input vec_t v);
    unit_t u;
    logic [63:0] m [3];
    logic [31:0] c [3];
    logic [63:0] s, rem, len, sn, r;
    int k;
    c[0] = v.x; c[1] = v.y; c[2] = v.z;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i][31] ? (64'd1 << 32) - {32'd0, c[i]} : {32'd0, c[i]};
      s = s + m[i] * m[i];
    end
    if (s == 0) begin
      u = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
      return u;
    end
    len = floor_sqrt(s, rem);
    if (rem > len) len = len + 1;
    sn = s;
    k = 0;
    while (sn[63:62] == 2'b00) begin
      sn = sn << 2;
      k++;
    end
    r = floor_sqrt(sn, rem);
    u.ux   = scale_component(v.x, k, r);
    u.uy   = scale_component(v.y, k, r);
    u.uz   = scale_component(v.z, k, r);
    u.len  = len[31:0];
    u.zero = 1'b0;
    return u;
  endfunction

  // Send one vector: random gap at the start of each burst, then hold valid until accepted.
  int burst_left;
  task automatic send_vector(input vec_t v, input bit known, input unit_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {v.z, v.y, v.x};
    expected_units.push_back(known ? r : normalize(v));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_component();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15) - 8;                    // tiny
      1: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 0);
      2: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return 32'($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  row_t directed[$];
  vec_t  rv;
  unit_t none;

  initial begin
    errors = 0;
    sending_done = 0;
    burst_left = 0;
    none = '{0, 0, 0, 0, 0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero vector flags and zeroes everything
    directed.push_back('{'{32'd0, 32'd0, 32'd0}, 1, '{0, 0, 0, 0, 1'b1}});
    // unit along each axis (y negative): component +/-1.0, length 1.0
    directed.push_back('{'{32'h0001_0000, 0, 0}, 1,
                         '{32'h4000_0000, 0, 0, 32'h0001_0000, 0}});
    directed.push_back('{'{0, 32'hFFFF_0000, 0}, 1,
                         '{0, 32'hC000_0000, 0, 32'h0001_0000, 0}});
    directed.push_back('{'{0, 0, 32'h0001_0000}, 1,
                         '{0, 0, 32'h4000_0000, 32'h0001_0000, 0}});
    // most negative component alone: magnitude 2^31
    directed.push_back('{'{32'h8000_0000, 0, 0}, 1,
                         '{32'hC000_0000, 0, 0, 32'h8000_0000, 0}});
    // smallest nonzero
    directed.push_back('{'{32'd1, 0, 0}, 1, '{32'h4000_0000, 0, 0, 32'd1, 0}});
    directed.push_back('{'{0, 0, 32'hFFFF_FFFF}, 1, '{0, 0, 32'hC000_0000, 32'd1, 0}});
    // extremes and mixed values, predictor-checked
    directed.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, none});
    directed.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, none});
    directed.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}, 0, none});
    directed.push_back('{'{32'd1, 32'd1, 32'd1}, 0, none});
    directed.push_back('{'{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}, 0, none});
    directed.push_back('{'{32'h0003_0000, 32'h0004_0000, 0}, 0, none});
    directed.push_back('{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0}, 0, none});

    foreach (directed[i]) send_vector(directed[i].v, directed[i].known, directed[i].r);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        // drain the pipe completely before continuing
        in_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_units.size() != 0) @(negedge clk);
      end
      rv.x = rand_component();
      rv.y = rand_component();
      rv.z = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_component();
      if ($urandom_range(0, 60) == 0) rv = '{0, 0, 0};
      send_vector(rv, 0, none);
    end
    in_tvalid <= 1'b0;
    sending_done = 1;
  end

  // Receiver: stalls in its own pattern, long ready runs mixed in.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      case ($urandom_range(0, 3))
        0: out_tready <= 1'b0;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= 1'b1;
      endcase
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest outstanding one.
  unit_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected result %h / %b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_units.pop_front();
        if (out_tdata[31:0] !== want.ux) begin
          $display("%0t: unit_x exp %h got %h", $time, want.ux, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== want.uy) begin
          $display("%0t: unit_y exp %h got %h", $time, want.uy, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[95:64] !== want.uz) begin
          $display("%0t: unit_z exp %h got %h", $time, want.uz, out_tdata[95:64]);
          errors++;
        end
        if (out_tdata[127:96] !== want.len) begin
          $display("%0t: vec_length exp %h got %h", $time, want.len, out_tdata[127:96]);
          errors++;
        end
        if (out_tuser !== want.zero) begin
          $display("%0t: zero_length exp %b got %b", $time, want.zero, out_tuser);
          errors++;
        end
      end
    end
  end

  // End of run: drain, then idle so that any unexpected extra result is caught.
  initial begin
    wait (sending_done);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (LATENCY * 2) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vnorm_pkg.sv
rtl/vnorm_sq_lane.sv
rtl/vnorm_sqrt.sv
rtl/vnorm_div_lane.sv
rtl/vector_normalize_unit.sv
sim/testbench.sv
